// File: design/qdc_pkg.sv
// Shared types, constants and the transition table for the quadrature detent counter.
// No dependencies.
package qdc_pkg;

  localparam int NUM_ENCODERS = 2;
  localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam int PINS_W = 2;
  localparam int ACC_W = 16;
  localparam int DELTA_W = 15;
  localparam int REQ_W = 2;

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEED   = 2'd2;

  typedef struct packed {
    logic [PINS_W-1:0]       pins;
    logic signed [ACC_W-1:0] count;
  } qdc_entry_t;

  localparam int ENTRY_W = $bits(qdc_entry_t);

  function automatic logic signed [1:0] qdc_step(input logic [3:0] t);
    logic signed [1:0] s;
    case (t)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// File: design/qdc_state_ram.sv
// Per-channel state memory: one write port, one read port, registered read data.
// No dependencies.
module qdc_state_ram #(
  parameter int WIDTH  = 18,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/qdc_out_buf.sv
// Two-entry output queue that decouples result transactions from the update stage.
// Depends on qdc_pkg.
module qdc_out_buf (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic signed [qdc_pkg::DELTA_W-1:0] push_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [qdc_pkg::DELTA_W-1:0] detent_delta,
  output logic [1:0]                         count
);
  import qdc_pkg::*;

  logic signed [DELTA_W-1:0] slot [2];
  logic                      wr_ptr;
  logic                      rd_ptr;
  logic                      pop;

  assign pop          = out_valid && !out_stall;
  assign out_valid    = (count != 2'd0);
  assign detent_delta = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/quadrature_detent_counter.sv
// Top level of the quadrature detent counter: read stage, update stage, output queue.
// Depends on qdc_pkg, qdc_state_ram and qdc_out_buf.
//
//   channel | direction | signals                                   | handshake
//   in      | input     | req_type, channel, level_a, level_b       | in_valid / in_stall
//   out     | output    | detent_delta                              | out_valid / out_stall
//   cfg     | input     | cfg_data (half_detent_mode)               | cfg_write
//
// One transaction per cycle while in_stall is low; a take result is registered in the update
// stage, then in the output queue. The state memory is read on accept and written back in
// the next cycle; a back-to-back transaction on the same channel takes the forwarded value.
// Reset clears the per-entry valid bits, so unwritten channels read as zero; no clearing pass.
// in_stall is high in reset and when the two-entry output queue cannot take another result.
module quadrature_detent_counter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [qdc_pkg::REQ_W-1:0]          req_type,
  input  logic                               channel,
  input  logic                               level_a,
  input  logic                               level_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [qdc_pkg::DELTA_W-1:0] detent_delta,
  input  logic                               cfg_write,
  input  logic                               cfg_data
);
  import qdc_pkg::*;

  logic                    half_mode;
  logic                    accept;
  logic                    in_ok;
  logic [IDX_W-1:0]        in_idx;
  logic [NUM_ENCODERS-1:0] ent_valid;

  logic                    s1_valid;
  logic [REQ_W-1:0]        s1_req;
  logic                    s1_ok;
  logic [IDX_W-1:0]        s1_idx;
  logic [PINS_W-1:0]       s1_curr;
  logic                    s1_rd_ok;
  logic                    fwd_hit;
  qdc_entry_t              fwd_data;
  qdc_entry_t              ram_rd;
  qdc_entry_t              cur;
  qdc_entry_t              upd;

  logic                    wr_en;
  logic signed [1:0]       step;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W:0]   biased;
  logic signed [ACC_W:0]   quot;
  logic signed [ACC_W-1:0] det;
  logic signed [DELTA_W-1:0] res;
  logic                    push;
  logic [1:0]              q_count;
  logic [2:0]              demand;
  logic [2:0]              room;

  assign in_ok  = (int'(channel) < NUM_ENCODERS);
  assign in_idx = in_ok ? IDX_W'(channel) : '0;
  assign accept = in_valid && !in_stall;

  assign push   = s1_valid && (s1_req == REQ_TAKE);
  assign demand = {1'b0, q_count} + {2'b00, push};
  assign room   = 3'd2 + {2'b00, out_valid && !out_stall};
  assign in_stall = rst || (demand >= room);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_mode <= 1'b0;
    end else if (cfg_write) begin
      half_mode <= cfg_data;
    end
  end

  assign wr_en = s1_valid && s1_ok &&
                 (s1_req == REQ_SAMPLE || s1_req == REQ_TAKE || s1_req == REQ_SEED);

  qdc_state_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_ENCODERS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_idx),
    .wr_data(upd),
    .rd_en  (accept),
    .rd_addr(in_idx),
    .rd_data(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      ent_valid <= '0;
      fwd_hit   <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (wr_en) begin
        ent_valid[s1_idx] <= 1'b1;
      end
      if (accept) begin
        fwd_hit <= wr_en && (s1_idx == in_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req   <= req_type;
      s1_ok    <= in_ok;
      s1_idx   <= in_idx;
      s1_curr  <= {level_a, level_b};
      s1_rd_ok <= ent_valid[in_idx];
      fwd_data <= upd;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (s1_rd_ok) begin
      cur = ram_rd;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    step   = qdc_step({cur.pins, s1_curr});
    sum    = {cur.count[ACC_W-1], cur.count} + (ACC_W+1)'(step);
    biased = {cur.count[ACC_W-1], cur.count} +
             (cur.count[ACC_W-1] ? (half_mode ? 17'sd1 : 17'sd3) : 17'sd0);
    quot   = half_mode ? (biased >>> 1) : (biased >>> 2);
    det    = quot[ACC_W-1:0];
    upd    = cur;
    res    = '0;
    case (s1_req)
      REQ_SAMPLE: begin
        upd.pins = s1_curr;
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          upd.count = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          upd.count = sum[ACC_W-1:0];
        end
      end
      REQ_TAKE: begin
        upd.count = cur.count - (half_mode ? (det <<< 1) : (det <<< 2));
        res       = s1_ok ? det[DELTA_W-1:0] : '0;
      end
      REQ_SEED: begin
        upd.pins = s1_curr;
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  qdc_out_buf u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (res),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .detent_delta(detent_delta),
    .count       (q_count)
  );

endmodule

// File: design/qdc_checker.sv
// Port-level checks for the quadrature detent counter, bound to the top level.
// Depends on qdc_pkg and quadrature_detent_counter.
module qdc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [qdc_pkg::REQ_W-1:0]          req_type,
  input logic                               channel,
  input logic                               level_a,
  input logic                               level_b,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [qdc_pkg::DELTA_W-1:0] detent_delta,
  input logic                               cfg_write,
  input logic                               cfg_data
);
  import qdc_pkg::*;

  logic take_acc;

  assign take_acc  = in_valid && !in_stall && (req_type == REQ_TAKE);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(detent_delta))
    else $error("held result transaction changed");

  a_take_result: assert property (@(posedge clk) disable iff (rst)
    take_acc |-> ##2 out_valid)
    else $error("take transaction produced no result");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !take_acc) ##1 (!out_valid && !take_acc) |=> !out_valid)
    else $error("result transaction without a take");

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (.*);
